// ----- hw/rtl/pip_pkg.sv -----
package pip_pkg;

	localparam int CMD_W   = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_QUERY  = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_FEW  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_DRAIN
	} walk_state_t;

	// Tags travelling with each vertex read out of the table.
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} edge_ctl_t;

	typedef struct packed {
		logic done;
		logic odd;
	} edge_res_t;

endpackage

// ----- hw/rtl/pip_ram.sv -----
module pip_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/pip_edge_unit.sv -----
module pip_edge_unit import pip_pkg::*; #(
	parameter int CB = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  edge_ctl_t         ctl,
	input  logic [2*CB-1:0]   rdata,
	input  logic [CB-1:0]     px,
	input  logic [CB-1:0]     py,
	output edge_res_t         res
);

	logic signed [CB-1:0] xi, yi, xj, yj, pxs, pys;
	logic [2*CB-1:0]      prev_q;
	logic                 straddle;

	logic signed [CB:0]   a_s2, dy_s2, c_s2, d_s2;
	logic                 v_s2, last_s2, cross_s2, dyneg_s2;

	logic signed [2*CB+1:0] p1_s3, p2_s3;
	logic                   v_s3, last_s3, cross_s3, dyneg_s3;

	logic parity_q;
	logic tog;

	assign xi  = $signed(rdata[CB-1:0]);
	assign yi  = $signed(rdata[2*CB-1:CB]);
	assign xj  = $signed(prev_q[CB-1:0]);
	assign yj  = $signed(prev_q[2*CB-1:CB]);
	assign pxs = $signed(px);
	assign pys = $signed(py);

	// An edge counts only when exactly one end lies strictly above the point.
	assign straddle = (yi > pys) != (yj > pys);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= ctl.valid;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.valid) begin
			prev_q <= rdata;
		end
		a_s2     <= $signed({pxs[CB-1], pxs}) - $signed({xi[CB-1], xi});
		dy_s2    <= $signed({yj[CB-1], yj}) - $signed({yi[CB-1], yi});
		c_s2     <= $signed({xj[CB-1], xj}) - $signed({xi[CB-1], xi});
		d_s2     <= $signed({pys[CB-1], pys}) - $signed({yi[CB-1], yi});
		cross_s2 <= ctl.valid && !ctl.first && straddle;
		dyneg_s2 <= yj < yi;
		last_s2  <= ctl.last;

		p1_s3    <= (2*CB+2)'(a_s2) * (2*CB+2)'(dy_s2);
		p2_s3    <= (2*CB+2)'(c_s2) * (2*CB+2)'(d_s2);
		cross_s3 <= cross_s2;
		dyneg_s3 <= dyneg_s2;
		last_s3  <= last_s2;
	end

	// With a negative y span the cross-multiplied comparison flips.
	assign tog = cross_s3 && (dyneg_s3 ? (p1_s3 > p2_s3) : (p1_s3 < p2_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
		end else if (ctl.valid && ctl.first) begin
			parity_q <= 1'b0;
		end else if (v_s3) begin
			parity_q <= parity_q ^ tog;
		end
	end

	assign res.done = v_s3 && last_s3;
	assign res.odd  = parity_q ^ tog;

endmodule

// ----- hw/rtl/point_in_polygon_test.sv -----
// Point-in-polygon test by the even-odd crossing rule over a stored vertex table.
// Input channel: cmd, coord_x and coord_y are taken at a rising edge where start
// is high and busy is low. cmd clears the table, appends one vertex, or queries
// whether the point (coord_x, coord_y) lies inside the closed polygon.
// Output channel: every beat produces exactly one result, shown on inside_res,
// status and count_now for one cycle while done is high. The receiver cannot
// stall, so the result must be taken in that cycle.
// Clear, append, reserved commands and queries on fewer than three vertices give
// their result in the cycle after acceptance, and busy stays low.
// A query on n vertices reads n + 1 table entries, one per cycle from a single
// read port, then passes through a difference, multiply and compare pipeline,
// and the next beat may be accepted in the cycle its result is shown. The
// read port of the vertex memory sets the rate: one edge per cycle.
// Reset clears the vertex count and all control state; table contents are
// left as they are and only entries written since the last clear are read.
module point_in_polygon_test import pip_pkg::*; #(
	parameter int MAX_VERTS  = 64,
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [COORD_BITS-1:0] coord_x,
	input  logic [COORD_BITS-1:0] coord_y,
	output logic                  done,
	output logic                  inside_res,
	output logic [STATUS_W-1:0]   status,
	output logic [COUNT_W-1:0]    count_now
);

	localparam int AW     = $clog2(MAX_VERTS);
	localparam int CNT_W  = $clog2(MAX_VERTS + 1);
	localparam int EXT_W  = CNT_W + COUNT_W;

	walk_state_t state_q, state_d;

	logic [CNT_W-1:0]        count_q, count_d;
	logic [CNT_W-1:0]        iss_q;
	logic [COORD_BITS-1:0]   px_q, py_q;
	logic                    accept, issuing;
	logic                    room, enough;
	logic                    we;
	logic [AW-1:0]           raddr;
	logic [2*COORD_BITS-1:0] rdata;
	edge_ctl_t               ctl_q;
	edge_res_t               res;
	logic [EXT_W-1:0]        cnt_ext;

	logic                    done_q, inside_q;
	status_t                 status_q;
	logic [COUNT_W-1:0]      count_now_q;

	assign accept = start && !busy;
	assign room   = count_q < CNT_W'(MAX_VERTS);
	assign enough = count_q >= CNT_W'(3);
	assign we     = accept && (cmd_t'(cmd) == CMD_APPEND) && room;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (cmd_t'(cmd) == CMD_QUERY) && enough) begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (iss_q == count_q) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (res.done) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// The first read fetches the last vertex, which closes the polygon.
	always_comb begin
		busy    = 1'b1;
		issuing = 1'b0;
		raddr   = iss_q[AW-1:0] - AW'(1);
		unique case (state_q)
			S_IDLE:  busy = 1'b0;
			S_WALK: begin
				issuing = 1'b1;
				if (iss_q == '0) begin
					raddr = count_q[AW-1:0] - AW'(1);
				end
			end
			S_DRAIN: busy = 1'b1;
			default: busy = 1'b1;
		endcase
	end

	always_comb begin
		count_d = count_q;
		if (accept) begin
			unique case (cmd_t'(cmd))
				CMD_CLEAR:  count_d = '0;
				CMD_APPEND: if (room) count_d = count_q + CNT_W'(1);
				CMD_QUERY:  count_d = count_q;
				default:    count_d = count_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			iss_q   <= '0;
			ctl_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			iss_q       <= issuing ? iss_q + CNT_W'(1) : '0;
			ctl_q.valid <= issuing;
			ctl_q.first <= issuing && (iss_q == '0);
			ctl_q.last  <= issuing && (iss_q == count_q);
			done_q      <= (accept && !((cmd_t'(cmd) == CMD_QUERY) && enough)) || res.done;
		end
	end

	assign cnt_ext = EXT_W'(count_d);

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
		if (res.done) begin
			inside_q <= res.odd;
			status_q <= STAT_OK;
		end else begin
			inside_q <= 1'b0;
			status_q <= STAT_OK;
			if (accept) begin
				unique case (cmd_t'(cmd))
					CMD_APPEND: if (!room) status_q <= STAT_FULL;
					CMD_QUERY:  if (!enough) status_q <= STAT_FEW;
					CMD_CLEAR:  status_q <= STAT_OK;
					default:    status_q <= STAT_OK;
				endcase
			end
		end
		count_now_q <= cnt_ext[COUNT_W-1:0];
	end

	pip_ram #(
		.WIDTH(2*COORD_BITS),
		.DEPTH(MAX_VERTS)
	) u_vert_ram (
		.clk  (clk),
		.we   (we),
		.waddr(count_q[AW-1:0]),
		.wdata({coord_y, coord_x}),
		.raddr(raddr),
		.rdata(rdata)
	);

	pip_edge_unit #(
		.CB(COORD_BITS)
	) u_edge (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl_q),
		.rdata (rdata),
		.px    (px_q),
		.py    (py_q),
		.res   (res)
	);

	assign done       = done_q;
	assign inside_res = inside_q;
	assign status     = status_q;
	assign count_now  = count_now_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy)
		else $error("result shown while a query is still walking");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VERTS))
		else $error("vertex count beyond table depth");

	a_walk_enough: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> enough)
		else $error("walk started on fewer than three vertices");

	a_finish_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> (state_q == S_DRAIN))
		else $error("edge pipeline finished outside the drain phase");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !we)
		else $error("table written during a query");

endmodule
